// ===== sv/hcd_pkg.sv =====
package hcd_pkg;

   localparam int SIZE_BITS_DEF = 32;

   // parser phases
   typedef enum logic [2:0] {
      PH_LINE = 3'd0,
      PH_DATA = 3'd1,
      PH_SKIP = 3'd2,
      PH_DONE = 3'd3,
      PH_ERR  = 3'd4
   } phase_type;

   // status codes on the response
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [7:0] CH_LA  = 8'h61;
   localparam logic [7:0] CH_LF_ = 8'h66;
   localparam logic [7:0] CH_UA  = 8'h41;
   localparam logic [7:0] CH_UF  = 8'h46;
   localparam logic [3:0] HEX_TEN = 4'd10;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.is_hex = 1'b0;
      h.value  = 4'd0;
      if (b >= CH_0 && b <= CH_9) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CH_0);
      end else if (b >= CH_LA && b <= CH_LF_) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CH_LA) + HEX_TEN;
      end else if (b >= CH_UA && b <= CH_UF) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CH_UA) + HEX_TEN;
      end
      return h;
   endfunction

endpackage

// ===== sv/hcd_if.sv =====
interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface hcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic [1:0] status;

   modport source (output valid, output data_byte, output byte_valid, output status,
                   input ready);
   modport sink (input valid, input data_byte, input byte_valid, input status,
                 output ready);
endinterface

// ===== sv/http_chunked_decoder.sv =====
// Decodes an HTTP chunked body at one byte per clock. Each accepted request byte
// updates the parser state in the same cycle and, when it yields a payload byte
// or a first status report, loads the response register; a request is taken
// whenever that register is empty or being drained, so throughput is one byte
// per cycle, and the input stalls only while a response waits on the consumer.
// Status 2 (malformed) tells the consumer to drop bytes already streamed; after
// status 1 or 2 further bytes are swallowed until is_last, which returns the
// parser to the start of a new body. No warm-up after reset.
module http_chunked_decoder
   import hcd_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hcd_req_if.sink   req_ch,
   hcd_rsp_if.source rsp_ch
);

   phase_type            phase_ff, phase_in;
   logic                 pending_cr_ff, pending_cr_in;
   logic                 size_ended_ff, size_ended_in;
   logic                 saw_digit_ff, saw_digit_in;
   logic                 skip_ff, skip_in;
   logic [SIZE_BITS-1:0] chunk_size_ff, chunk_size_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_bv_ff;
   logic [1:0]           rsp_status_ff;

   logic                 accept;
   logic                 emit_byte;
   logic [1:0]           report;
   hex_type              hex;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign hex          = hex_decode(req_ch.in_byte);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      pending_cr_in = pending_cr_ff;
      size_ended_in = size_ended_ff;
      saw_digit_in  = saw_digit_ff;
      skip_in       = skip_ff;
      chunk_size_in = chunk_size_ff;
      bytes_left_in = bytes_left_ff;
      unique case (phase_ff)
         PH_LINE: begin
            if (pending_cr_ff && req_ch.in_byte == CH_LF) begin
               if (!saw_digit_ff) begin
                  phase_in = PH_ERR;
               end else if (chunk_size_ff == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = chunk_size_ff;
                  phase_in      = PH_DATA;
               end
            end else begin
               pending_cr_in = (req_ch.in_byte == CH_CR);
               if (!size_ended_ff) begin
                  if (!hex.is_hex) begin
                     size_ended_in = 1'b1;
                  end else if (|chunk_size_ff[SIZE_BITS-1 -: 4]) begin
                     // next digit would overflow the size counter
                     phase_in = PH_ERR;
                  end else begin
                     chunk_size_in = {chunk_size_ff[SIZE_BITS-5:0], hex.value};
                     saw_digit_in  = 1'b1;
                  end
               end
            end
         end
         PH_DATA: begin
            bytes_left_in = bytes_left_ff - 1'b1;
            if (bytes_left_ff == SIZE_BITS'(1)) begin
               phase_in = PH_SKIP;
               skip_in  = 1'b0;
            end
         end
         PH_SKIP: begin
            if (skip_ff) begin
               skip_in       = 1'b0;
               phase_in      = PH_LINE;
               pending_cr_in = 1'b0;
               size_ended_in = 1'b0;
               saw_digit_in  = 1'b0;
               chunk_size_in = '0;
            end else begin
               skip_in = 1'b1;
            end
         end
         PH_DONE, PH_ERR: begin
         end
         default: begin
         end
      endcase
      if (req_ch.is_last) begin
         phase_in      = PH_LINE;
         pending_cr_in = 1'b0;
         size_ended_in = 1'b0;
         saw_digit_in  = 1'b0;
         skip_in       = 1'b0;
         chunk_size_in = '0;
         bytes_left_in = '0;
      end
   end

   // outputs
   always_comb begin
      emit_byte = (phase_ff == PH_DATA);
      report    = ST_BUSY;
      if (phase_ff == PH_LINE && phase_in != PH_LINE && !req_ch.is_last) begin
         report = (phase_in == PH_DONE) ? ST_DONE :
                  (phase_in == PH_ERR)  ? ST_BAD  : ST_BUSY;
      end else if (phase_ff == PH_LINE && req_ch.is_last) begin
         // phase_in is overridden by is_last, so recompute what the line did
         if (pending_cr_ff && req_ch.in_byte == CH_LF && saw_digit_ff
             && chunk_size_ff == '0) begin
            report = ST_DONE;
         end else begin
            report = ST_BAD;
         end
      end else if (req_ch.is_last && phase_ff != PH_DONE && phase_ff != PH_ERR) begin
         // body ends before the terminating chunk
         report = ST_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE;
         pending_cr_ff <= 1'b0;
         size_ended_ff <= 1'b0;
         saw_digit_ff  <= 1'b0;
         skip_ff       <= 1'b0;
         chunk_size_ff <= '0;
         bytes_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            pending_cr_ff <= pending_cr_in;
            size_ended_ff <= size_ended_in;
            saw_digit_ff  <= saw_digit_in;
            skip_ff       <= skip_in;
            chunk_size_ff <= chunk_size_in;
            bytes_left_ff <= bytes_left_in;
            rsp_valid_ff  <= emit_byte || (report != ST_BUSY);
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= emit_byte ? req_ch.in_byte : 8'd0;
         rsp_bv_ff     <= emit_byte;
         rsp_status_ff <= report;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.data_byte  = rsp_byte_ff;
   assign rsp_ch.byte_valid = rsp_bv_ff;
   assign rsp_ch.status     = rsp_status_ff;

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

   a_data_emits: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DATA |=> rsp_valid_ff && rsp_bv_ff)
      else $error("payload request produced no byte");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("request stalled with empty response register");

   // after a report the last byte is swallowed, otherwise it carries a status
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.is_last |=> phase_ff == PH_LINE && chunk_size_ff == '0
         && ((rsp_valid_ff && rsp_status_ff != ST_BUSY)
            || $past(phase_ff) == PH_DONE || $past(phase_ff) == PH_ERR))
      else $error("last byte did not restart parser");

endmodule
